>>> rtl/iou_trk_pkg.sv
`timescale 1ns / 1ps

package iou_trk_pkg;

  localparam int TRACK_SLOTS_DEF = 32;
  localparam int COORD_BITS_DEF  = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_IOU_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_VELOCITY_GAIN = 2'd1;
  localparam logic [1:0] REG_MAX_AGE       = 2'd2;

  // Input item kinds.
  localparam logic [1:0] MODE_BEGIN = 2'd0;
  localparam logic [1:0] MODE_DET   = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_MATCH = 2'd1;
  localparam logic [1:0] STAT_NEW   = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  // Steps of the IoU compare and of the velocity update.
  localparam logic [3:0] IOU_LAST = 4'd12;
  localparam logic [3:0] VEL_LAST = 4'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREA,
    ST_AREA_CAP,
    ST_RD,
    ST_EVAL,
    ST_IOU,
    ST_RESOLVE,
    ST_FIX_RD,
    ST_VEL,
    ST_NEW,
    ST_DONE
  } trk_state_t;

endpackage

>>> rtl/iou_track_associator_unit.sv
`timescale 1ns / 1ps

// Begin-frame and end-frame items scan every slot before reaching the result register; an unused
// mode goes there directly. A detection computes its area, then scans every slot with an IoU compare
// for each valid slot of its class, then opens a track or updates a match (one shared multiplier).
// The next item is accepted in the cycle after the result is loaded, while that result may wait.
// Reset (rst, synchronous) clears the valid bits, the track count and the sequencer and sets the
// id counter to one; slot memories are not cleared and their contents are used only while valid.
module iou_track_associator_unit
  import iou_trk_pkg::*;
#(
  parameter int TRACK_SLOTS = TRACK_SLOTS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // det_x, det_y, det_w, det_h, det_class
  input  logic [1:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // assigned id, active count, zero fill
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int CB = COORD_BITS;
  localparam int L  = CB + 1;
  localparam int IW = $clog2(TRACK_SLOTS);
  localparam int CW = $clog2(TRACK_SLOTS + 1);

  trk_state_t state, state_next;

  logic [7:0] iou_threshold, velocity_gain;
  logic [3:0] max_age;

  logic [1:0]    mode;
  logic [CB-1:0] dx, dy, dw, dh;
  logic [7:0]    dc;

  logic [TRACK_SLOTS-1:0] slot_valid;
  logic [CW-1:0]          count;
  logic [15:0]            id_counter;

  logic [IW-1:0] idx, best, free_slot;
  logic          best_found, free_found;
  logic [3:0]    k;

  logic [CB-1:0] ox, oy;
  logic [2*L-1:0] darea, inter, uni, bnum, bden, mul_q;
  logic [4*L-1:0] acc1, acc2;
  logic signed [CB:0] velx, vely;

  logic [1:0]  res_status;
  logic [15:0] res_tid;
  logic [1:0]  out_status;
  logic [15:0] out_tid;
  logic [5:0]  out_count;

  // Slot memories.
  logic [15:0]        mem_id    [TRACK_SLOTS];
  logic [7:0]         mem_class [TRACK_SLOTS];
  logic [CB-1:0]      mem_x     [TRACK_SLOTS];
  logic [CB-1:0]      mem_y     [TRACK_SLOTS];
  logic [CB-1:0]      mem_w     [TRACK_SLOTS];
  logic [CB-1:0]      mem_h     [TRACK_SLOTS];
  logic [4:0]         mem_age   [TRACK_SLOTS];
  logic signed [CB:0] mem_vx    [TRACK_SLOTS];
  logic signed [CB:0] mem_vy    [TRACK_SLOTS];

  logic [15:0]        rd_id;
  logic [7:0]         rd_class;
  logic [CB-1:0]      rd_x, rd_y, rd_w, rd_h;
  logic [4:0]         rd_age;
  logic signed [CB:0] rd_vx, rd_vy;

  logic [IW-1:0]      raddr, waddr;
  logic               we_pos, we_box, we_tag;
  logic [CB-1:0]      wx, wy;
  logic [4:0]         wage;
  logic signed [CB:0] wvx, wvy;
  logic [L-1:0]       mul_a, mul_b;

  logic          in_xfer, last_slot, cand;
  logic          sgnx, sgny;
  logic [CB-1:0] magx, magy;
  logic [CB+15:0] ext_x, ext_y, ext_w, ext_h;

  function automatic logic [CB-1:0] overlap(input logic [CB-1:0] p1, input logic [CB-1:0] s1,
                                            input logic [CB-1:0] p2, input logic [CB-1:0] s2);
    logic [CB:0] e1, e2, lo, hi, d;
    e1 = {1'b0, p1} + {1'b0, s1};
    e2 = {1'b0, p2} + {1'b0, s2};
    lo = (p1 > p2) ? {1'b0, p1} : {1'b0, p2};
    hi = (e1 < e2) ? e1 : e2;
    d  = (hi > lo) ? hi - lo : '0;
    return d[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] move_sat(input logic [CB-1:0] p, input logic signed [CB:0] v);
    logic signed [CB+1:0] r;
    r = $signed({2'b00, p}) + $signed({v[CB], v});
    if (r < 0) begin
      return '0;
    end else if (r > $signed({2'b00, {CB{1'b1}}})) begin
      return '1;
    end
    return r[CB-1:0];
  endfunction

  function automatic logic [L-1:0] limb(input logic [2*L-1:0] v, input logic hi);
    return hi ? v[2*L-1:L] : v[L-1:0];
  endfunction

  function automatic logic [4*L-1:0] pp_shift(input logic [2*L-1:0] q, input logic [1:0] p);
    logic [4*L-1:0] w;
    w = {{(2*L){1'b0}}, q};
    case ({1'b0, p[1]} + {1'b0, p[0]})
      2'd0:    return w;
      2'd1:    return w << L;
      default: return w << (2 * L);
    endcase
  endfunction

  // Rounded to nearest, ties away from zero.
  function automatic logic signed [CB:0] vel_of(input logic [2*L-1:0] q, input logic pos);
    logic [2*L-1:0] t;
    logic [CB:0]    m;
    t = q + (2*L)'(128);
    m = {1'b0, t[CB+7:8]};
    return pos ? $signed(m) : -$signed(m);
  endfunction

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign last_slot = (idx == IW'(TRACK_SLOTS - 1));
  assign cand      = (mode == MODE_DET) && slot_valid[idx] && (rd_class == dc);
  assign sgnx      = (dx >= rd_x);
  assign sgny      = (dy >= rd_y);
  assign magx      = sgnx ? dx - rd_x : rd_x - dx;
  assign magy      = sgny ? dy - rd_y : rd_y - dy;
  assign ext_x     = (CB + 16)'(s_axis_tdata[15:0]);
  assign ext_y     = (CB + 16)'(s_axis_tdata[31:16]);
  assign ext_w     = (CB + 16)'(s_axis_tdata[47:32]);
  assign ext_h     = (CB + 16)'(s_axis_tdata[63:48]);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (s_axis_tuser)
            MODE_BEGIN, MODE_END: state_next = ST_RD;
            MODE_DET:             state_next = ST_AREA;
            default:              state_next = ST_DONE;
          endcase
        end
      end
      ST_AREA:     state_next = ST_AREA_CAP;
      ST_AREA_CAP: state_next = ST_RD;
      ST_RD:       state_next = ST_EVAL;
      ST_EVAL: begin
        if (cand) begin
          state_next = ST_IOU;
        end else if (!last_slot) begin
          state_next = ST_RD;
        end else begin
          state_next = (mode == MODE_DET) ? ST_RESOLVE : ST_DONE;
        end
      end
      ST_IOU: begin
        if (k == IOU_LAST) begin
          state_next = last_slot ? ST_RESOLVE : ST_RD;
        end
      end
      ST_RESOLVE: begin
        if (best_found) begin
          state_next = ST_FIX_RD;
        end else if (free_found) begin
          state_next = ST_NEW;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FIX_RD: state_next = ST_VEL;
      ST_VEL: begin
        if (k == VEL_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_NEW: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory, multiplier and handshake controls.
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    raddr  = (state == ST_FIX_RD || state == ST_VEL) ? best : idx;
    waddr  = idx;
    we_pos = 1'b0;
    we_box = 1'b0;
    we_tag = 1'b0;
    wx     = dx;
    wy     = dy;
    wage   = '0;
    wvx    = '0;
    wvy    = '0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      ST_AREA: begin
        mul_a = L'(dw);
        mul_b = L'(dh);
      end
      ST_EVAL: begin
        if (mode == MODE_BEGIN && slot_valid[idx]) begin
          we_pos = 1'b1;
          wx     = move_sat(rd_x, rd_vx);
          wy     = move_sat(rd_y, rd_vy);
          wage   = (rd_age == 5'd31) ? rd_age : rd_age + 5'd1;
        end
      end
      ST_IOU: begin
        case (k)
          4'd0: begin
            mul_a = L'(ox);
            mul_b = L'(oy);
          end
          4'd1: begin
            mul_a = L'(rd_w);
            mul_b = L'(rd_h);
          end
          4'd3, 4'd4, 4'd5, 4'd6: begin
            mul_a = limb(inter, k[1] ^ k[0]);
            mul_b = limb(bden, ~k[0]);
          end
          4'd7, 4'd8, 4'd9, 4'd10: begin
            mul_a = limb(bnum, k[3] & (k[1] | k[0]));
            mul_b = limb(uni, k[3] & ~k[0]);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_VEL: begin
        waddr = best;
        mul_a = L'(k[0] ? magy : magx);
        mul_b = L'(velocity_gain);
        if (k == VEL_LAST) begin
          we_pos = 1'b1;
          we_box = 1'b1;
          wvx    = velx;
          wvy    = vely;
        end
      end
      ST_NEW: begin
        waddr  = free_slot;
        we_pos = 1'b1;
        we_box = 1'b1;
        we_tag = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_pos) begin
      mem_x[waddr]   <= wx;
      mem_y[waddr]   <= wy;
      mem_age[waddr] <= wage;
    end
    if (we_box) begin
      mem_w[waddr]  <= dw;
      mem_h[waddr]  <= dh;
      mem_vx[waddr] <= wvx;
      mem_vy[waddr] <= wvy;
    end
    if (we_tag) begin
      mem_id[waddr]    <= id_counter;
      mem_class[waddr] <= dc;
    end
    rd_id    <= mem_id[raddr];
    rd_class <= mem_class[raddr];
    rd_x     <= mem_x[raddr];
    rd_y     <= mem_y[raddr];
    rd_w     <= mem_w[raddr];
    rd_h     <= mem_h[raddr];
    rd_age   <= mem_age[raddr];
    rd_vx    <= mem_vx[raddr];
    rd_vy    <= mem_vy[raddr];
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      iou_threshold <= 8'd77;
      velocity_gain <= 8'd77;
      max_age       <= 4'd10;
      slot_valid    <= '0;
      count         <= '0;
      id_counter    <= 16'd1;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_IOU_THRESHOLD: iou_threshold <= cfg_data;
          REG_VELOCITY_GAIN: velocity_gain <= cfg_data;
          REG_MAX_AGE:       max_age <= cfg_data[3:0];
          default:           max_age <= max_age;
        endcase
      end
      if (state == ST_EVAL && mode == MODE_END && slot_valid[idx] &&
          rd_age > {1'b0, max_age}) begin
        slot_valid[idx] <= 1'b0;
        count           <= count - CW'(1);
      end
      if (state == ST_NEW) begin
        slot_valid[free_slot] <= 1'b1;
        count                 <= count + CW'(1);
        id_counter            <= (id_counter == 16'hffff) ? 16'd1 : id_counter + 16'd1;
      end
      if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode       <= s_axis_tuser;
      dx         <= ext_x[CB-1:0];
      dy         <= ext_y[CB-1:0];
      dw         <= ext_w[CB-1:0];
      dh         <= ext_h[CB-1:0];
      dc         <= s_axis_tdata[71:64];
      idx        <= '0;
      best_found <= 1'b0;
      free_found <= 1'b0;
      bnum       <= (2*L)'(iou_threshold);
      bden       <= (2*L)'(256);
      res_status <= STAT_DONE;
      res_tid    <= '0;
    end
    if (state == ST_AREA_CAP) begin
      darea <= mul_q;
    end
    if (state == ST_EVAL) begin
      k  <= '0;
      ox <= overlap(rd_x, rd_w, dx, dw);
      oy <= overlap(rd_y, rd_h, dy, dh);
      if (!slot_valid[idx] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= idx;
      end
      if (state_next == ST_RD) begin
        idx <= idx + IW'(1);
      end
    end
    if (state == ST_IOU) begin
      k <= k + 4'd1;
      case (k)
        4'd0: begin
          acc1 <= '0;
          acc2 <= '0;
        end
        4'd1: inter <= mul_q;
        4'd2: uni <= mul_q + darea - inter;
        4'd4, 4'd5, 4'd6, 4'd7: acc1 <= acc1 + pp_shift(mul_q, k[1:0]);
        4'd8, 4'd9, 4'd10, 4'd11: acc2 <= acc2 + pp_shift(mul_q, k[1:0]);
        default: begin
          // Strictly greater keeps the first slot on ties.
          if (acc1 > acc2) begin
            best_found <= 1'b1;
            best       <= idx;
            bnum       <= inter;
            bden       <= uni;
          end
          if (state_next == ST_RD) begin
            idx <= idx + IW'(1);
          end
        end
      endcase
    end
    if (state == ST_RESOLVE && !best_found && !free_found) begin
      res_status <= STAT_FULL;
    end
    if (state == ST_FIX_RD) begin
      k <= '0;
    end
    if (state == ST_VEL) begin
      k <= k + 4'd1;
      case (k)
        4'd1: velx <= vel_of(mul_q, sgnx);
        4'd2: vely <= vel_of(mul_q, sgny);
        default: begin
          res_status <= STAT_MATCH;
          res_tid    <= rd_id;
        end
      endcase
    end
    if (state == ST_NEW) begin
      res_status <= STAT_NEW;
      res_tid    <= id_counter;
    end
    if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      out_status <= res_status;
      out_tid    <= res_tid;
      out_count  <= 6'(count);
    end
  end

  assign m_axis_tdata = {2'b00, out_count, out_tid};
  assign m_axis_tuser = out_status;

endmodule
